// ----- sv/rsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared constants and types for the range sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned DIST_W    = 32;
   localparam int unsigned ERR_W     = 16;
   localparam int unsigned COUNT_W   = 4;

   localparam logic [BYTE_W-1:0]  HDR0        = 8'hB4;
   localparam logic [BYTE_W-1:0]  HDR1        = 8'h69;
   localparam int unsigned        ERR_BIT_POS = 7;
   localparam logic [COUNT_W-1:0] FRAME_LEN   = 4'd8;
   localparam logic [COUNT_W-1:0] CHK_POS     = 4'd7;
   localparam logic [COUNT_W-1:0] POS_HDR0    = 4'd0;
   localparam logic [COUNT_W-1:0] POS_HDR1    = 4'd1;
   localparam logic [COUNT_W-1:0] POS_KIND    = 4'd2;
   localparam logic [COUNT_W-1:0] POS_PAYLOAD = 4'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              burst_end;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ERR_W-1:0]  error_code;
      logic              reading_valid;
      logic              frame_accepted;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/rsfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// rsfp_in_stage
// Input register holding one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rsfp_pkg::req_type req_data,
   output logic                  hold_valid,
   output rsfp_pkg::req_type     hold_data,
   input  wire logic             hold_take
);

   logic              valid_ff;
   logic              valid_in;
   rsfp_pkg::req_type data_ff;

   assign req_ready = !valid_ff || hold_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

`default_nettype wire

// ----- sv/rsfp_burst_track.sv -----
// ----------------------------------------------------------------------------
// rsfp_burst_track
// Per-burst header, checksum and payload tracking plus the held reading.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_burst_track (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire rsfp_pkg::req_type byte_in,
   output rsfp_pkg::rsp_type      result
);

   logic [rsfp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rsfp_pkg::BYTE_W-1:0]  xor_ff, xor_in;
   logic                         hdr_ok_ff, hdr_ok_in;
   logic                         kind_ff, kind_in;
   logic [rsfp_pkg::DIST_W-1:0]  payload_ff, payload_in;
   logic                         chk_ok_ff, chk_ok_in;
   logic [rsfp_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [rsfp_pkg::ERR_W-1:0]   err_ff, err_in;
   logic                         vld_ff, vld_in;
   logic                         accepted;

   always_comb begin
      count_in   = count_ff;
      xor_in     = xor_ff;
      hdr_ok_in  = hdr_ok_ff;
      kind_in    = kind_ff;
      payload_in = payload_ff;
      chk_ok_in  = chk_ok_ff;
      if (count_ff < rsfp_pkg::FRAME_LEN) begin
         if (count_ff == rsfp_pkg::POS_HDR0 && byte_in.rx_byte != rsfp_pkg::HDR0) begin
            hdr_ok_in = 1'b0;
         end
         if (count_ff == rsfp_pkg::POS_HDR1 && byte_in.rx_byte != rsfp_pkg::HDR1) begin
            hdr_ok_in = 1'b0;
         end
         if (count_ff == rsfp_pkg::POS_KIND) begin
            kind_in = byte_in.rx_byte[rsfp_pkg::ERR_BIT_POS];
         end
         if (count_ff >= rsfp_pkg::POS_PAYLOAD && count_ff < rsfp_pkg::CHK_POS) begin
            payload_in = {payload_ff[rsfp_pkg::DIST_W-rsfp_pkg::BYTE_W-1:0], byte_in.rx_byte};
         end
         if (count_ff < rsfp_pkg::CHK_POS) begin
            xor_in = xor_ff ^ byte_in.rx_byte;
         end else begin
            chk_ok_in = (byte_in.rx_byte == xor_ff);
         end
         count_in = count_ff + 1'b1;
      end

      accepted = (count_in == rsfp_pkg::FRAME_LEN) && hdr_ok_in && chk_ok_in;

      dist_in = dist_ff;
      err_in  = err_ff;
      vld_in  = vld_ff;
      if (byte_in.burst_end && accepted) begin
         if (kind_in) begin
            err_in  = payload_in[rsfp_pkg::ERR_W-1:0];
            dist_in = '0;
            vld_in  = 1'b0;
         end else begin
            dist_in = payload_in;
            err_in  = '0;
            vld_in  = 1'b1;
         end
      end

      result.distance       = dist_in;
      result.error_code     = err_in;
      result.reading_valid  = vld_in;
      result.frame_accepted = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         xor_ff     <= '0;
         hdr_ok_ff  <= 1'b1;
         kind_ff    <= 1'b0;
         payload_ff <= '0;
         chk_ok_ff  <= 1'b0;
         dist_ff    <= '0;
         err_ff     <= '0;
         vld_ff     <= 1'b0;
      end else if (step) begin
         dist_ff <= dist_in;
         err_ff  <= err_in;
         vld_ff  <= vld_in;
         if (byte_in.burst_end) begin
            count_ff   <= '0;
            xor_ff     <= '0;
            hdr_ok_ff  <= 1'b1;
            kind_ff    <= 1'b0;
            payload_ff <= '0;
            chk_ok_ff  <= 1'b0;
         end else begin
            count_ff   <= count_in;
            xor_ff     <= xor_in;
            hdr_ok_ff  <= hdr_ok_in;
            kind_ff    <= kind_in;
            payload_ff <= payload_in;
            chk_ok_ff  <= chk_ok_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/rsfp_out_stage.sv -----
// ----------------------------------------------------------------------------
// rsfp_out_stage
// Result register that holds one finished request until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rsfp_pkg::rsp_type load_data,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsfp_pkg::rsp_type      rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   rsfp_pkg::rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && slot_free) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- sv/range_sensor_frame_parser.sv -----
// ----------------------------------------------------------------------------
// range_sensor_frame_parser
// Checks header, length and XOR checksum of range sensor bursts and keeps
// the last good distance or error reading.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  req_      in         one received byte and its end-of-burst mark
//  rsp_      out        held reading and pass flag, one per finished burst
//
// Each byte request is held in the input register before it steps the burst
// tracker, and a burst's result loads the result register at the edge on which
// its last byte leaves the input register.
// The parser takes one byte every cycle; only a full result register with
// rsp_ready low stalls it, and then only when the waiting byte ends a burst.
// Synchronous reset returns the burst state to its start and clears the held reading to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module range_sensor_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_burst_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_distance,
   output logic [15:0]      rsp_error_code,
   output logic             rsp_reading_valid,
   output logic             rsp_frame_accepted
);

   rsfp_pkg::req_type req_data;
   rsfp_pkg::req_type hold_data;
   rsfp_pkg::rsp_type eval_data;
   rsfp_pkg::rsp_type rsp_data;
   logic              hold_valid;
   logic              hold_take;
   logic              slot_free;

   assign req_data.rx_byte   = req_rx_byte;
   assign req_data.burst_end = req_burst_end;

   assign hold_take = hold_valid && (!hold_data.burst_end || slot_free);

   rsfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .hold_valid (hold_valid),
      .hold_data  (hold_data),
      .hold_take  (hold_take)
   );

   rsfp_burst_track u_burst_track (
      .clock   (clock),
      .reset   (reset),
      .step    (hold_take),
      .byte_in (hold_data),
      .result  (eval_data)
   );

   rsfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (hold_take && hold_data.burst_end),
      .load_data (eval_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_distance       = rsp_data.distance;
   assign rsp_error_code     = rsp_data.error_code;
   assign rsp_reading_valid  = rsp_data.reading_valid;
   assign rsp_frame_accepted = rsp_data.frame_accepted;

endmodule

`default_nettype wire

// ----- sv/rsfp_checker.sv -----
// ----------------------------------------------------------------------------
// rsfp_checker
// Port-level checks on the frame parser result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_distance,
   input wire logic [15:0] rsp_error_code,
   input wire logic        rsp_reading_valid,
   input wire logic        rsp_frame_accepted
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_error_code) && $stable(rsp_reading_valid)
         && $stable(rsp_frame_accepted))
      else $error("Stalled result changed.");

   a_valid_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reading_valid |-> rsp_error_code == 16'd0)
      else $error("Distance reading carries an error code.");

   a_invalid_no_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reading_valid |-> rsp_distance == 32'd0)
      else $error("Invalid reading carries a distance.");

endmodule

bind range_sensor_frame_parser rsfp_checker u_rsfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_distance       (rsp_distance),
   .rsp_error_code     (rsp_error_code),
   .rsp_reading_valid  (rsp_reading_valid),
   .rsp_frame_accepted (rsp_frame_accepted)
);

`default_nettype wire
